>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the number formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that prop holds at every rising clock edge outside reset.
`define SSNF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that cond is never true at a rising clock edge outside reset.
`define SSNF_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SSNF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSNF_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/ssnf_pkg.sv
// Types, constants and segment tables shared by the number formatter.
package ssnf_pkg;

	localparam int VALUE_W    = 24;
	localparam int BCD_DIGITS = 7;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int SEG_W      = 8;
	localparam int NUM_POS    = 4;
	// Entry stage, one stage per input bit, then the output register.
	localparam int LATENCY    = VALUE_W + 2;

	localparam logic [1:0] OP_NUMBER = 2'd0;
	localparam logic [1:0] OP_OVFL   = 2'd1;
	localparam logic [1:0] OP_INVD   = 2'd2;

	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
	localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;
	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;

	// Position 0 is the leftmost digit.
	localparam logic [NUM_POS-1:0][SEG_W-1:0] TEXT_OVFL = {8'h38, 8'h71, 8'h1C, 8'h3F};
	localparam logic [NUM_POS-1:0][SEG_W-1:0] TEXT_INVD = {8'h5E, 8'h1C, 8'h54, 8'h30};

	typedef struct packed {
		logic               valid;
		logic [1:0]         opcode;
		logic               neg;
		logic [VALUE_W-1:0] bin;
		logic [BCD_W-1:0]   bcd;
	} ssnf_stage_t;

	typedef struct packed {
		logic [NUM_POS-1:0][SEG_W-1:0] seg;
		logic                          ovf;
	} ssnf_result_t;

	function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 8'h3F;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5B;
			4'd3:    s = 8'h4F;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6D;
			4'd6:    s = 8'h7D;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/ssnf_dd_cell.sv
// One shift-and-add-3 cell of the binary to decimal conversion chain.
module ssnf_dd_cell
	import ssnf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ssnf_stage_t stage_in,
	output ssnf_stage_t stage_out
);

	ssnf_stage_t      nxt;
	ssnf_stage_t      data_s1;
	logic             valid_s1;
	logic [BCD_W-1:0] adj;

	// Each decimal digit of five or more gets three added before the shift.
	always_comb begin
		logic [3:0] dg;
		adj = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			dg = stage_in.bcd[4*i +: 4];
			adj[4*i +: 4] = (dg >= 4'd5) ? dg + 4'd3 : dg;
		end
		nxt        = stage_in;
		nxt.bcd    = {adj[BCD_W-2:0], stage_in.bin[VALUE_W-1]};
		nxt.bin    = {stage_in.bin[VALUE_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	always_comb begin
		stage_out       = data_s1;
		stage_out.valid = valid_s1;
	end

endmodule

>>> rtl/ssnf_seg_format.sv
// Maps decimal digits and the request code to four segment patterns.
module ssnf_seg_format
	import ssnf_pkg::*;
(
	input  ssnf_stage_t  stage,
	output ssnf_result_t result
);

	logic [3:0] d6, d5, d4, d3, d2, d1, d0;
	logic       ge10, ge100, ge1000, fr_nz, ovf_num;

	// Digits d6..d3 are the integer part, d2..d0 the thousandths.
	assign d6 = stage.bcd[27:24];
	assign d5 = stage.bcd[23:20];
	assign d4 = stage.bcd[19:16];
	assign d3 = stage.bcd[15:12];
	assign d2 = stage.bcd[11:8];
	assign d1 = stage.bcd[7:4];
	assign d0 = stage.bcd[3:0];

	assign ge1000 = (d6 != 4'd0);
	assign ge100  = ge1000 || (d5 != 4'd0);
	assign ge10   = ge100 || (d4 != 4'd0);
	assign fr_nz  = (d2 != 4'd0) || (d1 != 4'd0) || (d0 != 4'd0);
	// The magnitude stays below ten million, so a positive integer part
	// always fits four digits; only negative values can overflow.
	assign ovf_num = stage.neg && ge1000;

	always_comb begin
		result.seg = '0;
		result.ovf = 1'b0;
		case (stage.opcode)
			OP_OVFL: begin
				result.seg = TEXT_OVFL;
			end
			OP_INVD: begin
				result.seg = TEXT_INVD;
			end
			OP_NUMBER: begin
				if (ovf_num) begin
					result.seg = TEXT_OVFL;
					result.ovf = 1'b1;
				end else if (stage.neg && fr_nz) begin
					result.seg[0] = SEG_MINUS;
					if (!ge10) begin
						result.seg[1] = digit_seg(d3) | SEG_POINT;
						result.seg[2] = digit_seg(d2);
						result.seg[3] = digit_seg(d1);
					end else if (!ge100) begin
						result.seg[1] = digit_seg(d4);
						result.seg[2] = digit_seg(d3) | SEG_POINT;
						result.seg[3] = digit_seg(d2);
					end else begin
						result.seg[1] = digit_seg(d5);
						result.seg[2] = digit_seg(d4);
						result.seg[3] = digit_seg(d3) | SEG_POINT;
					end
				end else if (fr_nz) begin
					if (!ge10) begin
						result.seg[0] = digit_seg(d3) | SEG_POINT;
						result.seg[1] = digit_seg(d2);
						result.seg[2] = digit_seg(d1);
						result.seg[3] = digit_seg(d0);
					end else if (!ge100) begin
						result.seg[0] = digit_seg(d4);
						result.seg[1] = digit_seg(d3) | SEG_POINT;
						result.seg[2] = digit_seg(d2);
						result.seg[3] = digit_seg(d1);
					end else if (!ge1000) begin
						result.seg[0] = digit_seg(d5);
						result.seg[1] = digit_seg(d4);
						result.seg[2] = digit_seg(d3) | SEG_POINT;
						result.seg[3] = digit_seg(d2);
					end else begin
						result.seg[0] = digit_seg(d6);
						result.seg[1] = digit_seg(d5);
						result.seg[2] = digit_seg(d4);
						result.seg[3] = digit_seg(d3) | SEG_POINT;
					end
				end else if (stage.neg) begin
					result.seg[0] = SEG_MINUS;
					result.seg[1] = ge100 ? digit_seg(d5) : SEG_BLANK;
					result.seg[2] = ge10 ? digit_seg(d4) : SEG_BLANK;
					result.seg[3] = digit_seg(d3);
				end else begin
					result.seg[0] = ge1000 ? digit_seg(d6) : SEG_BLANK;
					result.seg[1] = ge100 ? digit_seg(d5) : SEG_BLANK;
					result.seg[2] = ge10 ? digit_seg(d4) : SEG_BLANK;
					result.seg[3] = digit_seg(d3);
				end
			end
			default: begin
				result.seg = '0;
			end
		endcase
	end

endmodule

>>> rtl/seven_segment_number_formatter_unit.sv
// Top level of the four-digit seven-segment number formatter.
//
// A request is accepted at a rising clock edge where start is high and busy
// is low. It carries opcode (show number, show overflow text, show invalid
// text) and value_milli, a signed number in thousandths. The block answers
// every request with one result: four segment patterns, leftmost digit in
// seg_first, and out_of_range, which is set when a negative number needs
// more than three integer digits and the overflow text is shown instead.
// The result sits on the ports for exactly one cycle, marked by strobe.
//
// Inside, an entry register takes the magnitude of the value. A chain of 24
// identical double-dabble cells then turns it into seven decimal digits, one
// input bit per cell, and the formatter maps those digits to segments into
// the output register, which drives strobe and the segment ports. Each cell
// registers its step, so the latency is set by the length of the cell chain.
// A new request can be taken every cycle while busy is low; requests in flight
// never wait on each other, and results leave in request order.
//
// busy is high during reset and until the clock sets the ready register after
// it, then stays low. Reset empties the chain; requests in flight are dropped.
// The receiver cannot stall, so nothing upstream ever waits on it.
`include "assert_macros.svh"

module seven_segment_number_formatter_unit
	import ssnf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic signed [VALUE_W-1:0] value_milli,
	output logic                      strobe,
	output logic [SEG_W-1:0]          seg_first,
	output logic [SEG_W-1:0]          seg_second,
	output logic [SEG_W-1:0]          seg_third,
	output logic [SEG_W-1:0]          seg_fourth,
	output logic                      out_of_range
);

	logic               ready_q;
	logic               accept;
	logic               neg;
	logic [VALUE_W-1:0] raw;
	logic [VALUE_W-1:0] mag;

	ssnf_stage_t  entry_s1;
	logic         entry_valid_s1;
	ssnf_stage_t  chain [VALUE_W+1];
	ssnf_result_t fmt;

	logic                          strobe_q;
	logic [NUM_POS-1:0][SEG_W-1:0] seg_q;
	logic                          ovf_q;

	// The ready register is cleared by reset, set by the clock once reset is released, and stays set from then on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy   = !ready_q;
	assign accept = start && ready_q;

	// Two's complement magnitude. The most negative input gives 2^23, which
	// still fits the unsigned width.
	assign raw = value_milli;
	assign neg = raw[VALUE_W-1];
	assign mag = neg ? (~raw + {{(VALUE_W-1){1'b0}}, 1'b1}) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else begin
			entry_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		entry_s1.valid  <= 1'b0;
		entry_s1.opcode <= opcode;
		entry_s1.neg    <= neg;
		entry_s1.bin    <= mag;
		entry_s1.bcd    <= '0;
	end

	always_comb begin
		chain[0]       = entry_s1;
		chain[0].valid = entry_valid_s1;
	end

	// One cell per magnitude bit, most significant bit first.
	for (genvar i = 0; i < VALUE_W; i++) begin : g_cell
		ssnf_dd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (chain[i]),
			.stage_out (chain[i+1])
		);
	end

	ssnf_seg_format u_format (
		.stage  (chain[VALUE_W]),
		.result (fmt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= chain[VALUE_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		seg_q <= fmt.seg;
		ovf_q <= fmt.ovf;
	end

	assign strobe       = strobe_q;
	assign seg_first    = seg_q[0];
	assign seg_second   = seg_q[1];
	assign seg_third    = seg_q[2];
	assign seg_fourth   = seg_q[3];
	assign out_of_range = strobe_q && ovf_q;

	// Every request gives its result after the fixed latency.
	`SSNF_ASSERT(a_latency_fwd, clk, arst_n, accept |-> ##LATENCY strobe, "result missing after request")
	// No result appears without a request that far back.
	`SSNF_ASSERT(a_latency_back, clk, arst_n, strobe |-> $past(accept, LATENCY), "result without request")
	// The overflow flag comes only with a result that shows the overflow text.
	`SSNF_ASSERT(a_ovf_text, clk, arst_n, out_of_range |-> (strobe && seg_first == TEXT_OVFL[0] && seg_fourth == TEXT_OVFL[3]), "overflow flag without overflow text")

endmodule
